// ----- src/arr_pkg.sv -----
// Package for the ARP request responder: shared types and constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package arr_pkg;

  // Frame layout seen by the parser
  localparam int unsigned HDR_BYTES = 14;
  localparam int unsigned ARP_BYTES = 28;
  localparam int unsigned CHECK_LEN = HDR_BYTES + ARP_BYTES;
  localparam logic [7:0]  PAD_BYTE  = 8'h00;

  localparam int unsigned POS_W = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_STATION_MAC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STATION_IP  = CFG_IDX_W'(1);

  // One pending reply: the requester addresses captured from the request
  typedef struct packed {
    logic [47:0] hw_addr;
    logic [31:0] proto_addr;
  } job_t;

endpackage

`default_nettype wire

// ----- src/arp_request_responder_unit.sv -----
// ARP request responder, top level: config registers, parser, job queue, emitter.
// Depends on arr_pkg, arr_front, arr_jobq and arr_back.
//
// Usage:
// - Input channel (push/full): one received Ethernet word per accepted push,
//   starting at the destination MAC, frame_end_i high on the final word.
//   Words are taken at one per cycle while full is low.
// - Result channel (empty/pop): the oldest reply word sits on reply_byte_o and
//   reply_last_o while empty is low; pop takes it. Each reply is REPLY_BYTES
//   words, reply_last_o high on the final one.
// - Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 = station MAC, 1 = station IP) at once; other indexes are dropped.
// Latency: with no reply pending, the first reply word is visible the cycle
//   after the final request word is accepted. Throughput: one input word per
//   cycle, one reply word per cycle; a reply holds the emitter REPLY_BYTES pops.
// Stall: a two-entry job queue parts parser and emitter. While the receiver
//   holds pop low, the parser keeps taking words until two replies are pending
//   (the older one possibly part sent); full then holds every input word until
//   the emitter hands out the last word of the older reply.
// Reset: clears the station registers, parser position, queue and emitter.
`default_nettype none

module arp_request_responder_unit #(
  parameter int unsigned REPLY_BYTES = 60
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request words
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      frame_byte_i,
  input  wire logic                            frame_end_i,
  // reply words
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [7:0]                           reply_byte_o,
  output logic                                 reply_last_o,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [arr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [arr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import arr_pkg::*;

  localparam int unsigned JOB_DEPTH = 2;

  logic [47:0] station_mac_q;
  logic [31:0] station_ip_q;
  logic        accept;
  job_t        front_job, head_job;
  logic        front_push, job_done;

  // Station registers; write them only while the block is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_mac_q <= '0;
      station_ip_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STATION_MAC: station_mac_q <= cfg_data_i[47:0];
        REG_STATION_IP:  station_ip_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  arr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .frame_byte_i (frame_byte_i),
    .frame_end_i  (frame_end_i),
    .station_ip_i (station_ip_q),
    .job_o        (front_job),
    .job_push_o   (front_push)
  );

  arr_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (job_done),
    .data_o  (head_job),
    .empty_o (empty)
  );

  arr_back #(
    .REPLY_BYTES (REPLY_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_empty_i   (empty),
    .pop_i         (pop),
    .station_mac_i (station_mac_q),
    .station_ip_i  (station_ip_q),
    .reply_byte_o  (reply_byte_o),
    .reply_last_o  (reply_last_o),
    .job_done_o    (job_done)
  );

endmodule

`default_nettype wire

// ----- src/arr_front.sv -----
// Front end: counts and checks incoming request bytes, captures the requester.
// Depends on arr_pkg; feeds reply jobs into arr_jobq.
`default_nettype none

module arr_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   frame_byte_i,
  input  wire logic         frame_end_i,
  input  wire logic [31:0]  station_ip_i,
  output arr_pkg::job_t     job_o,
  output logic              job_push_o
);
  import arr_pkg::*;

  localparam logic [POS_W-1:0] SHA_POS = POS_W'(22);
  localparam logic [POS_W-1:0] SPA_POS = POS_W'(28);
  localparam logic [POS_W-1:0] SPA_END = POS_W'(32);
  localparam logic [POS_W-1:0] TPA_POS = POS_W'(38);
  localparam logic [POS_W-1:0] END_POS = POS_W'(CHECK_LEN);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             rej_q, rej_d;
  logic [47:0]      hw_q, hw_d;
  logic [31:0]      ip_q, ip_d;
  logic             ok;
  logic [1:0]       tpa_k;
  logic [31:0]      ip_shift;

  assign tpa_k    = 2'(pos_q - TPA_POS);
  assign ip_shift = station_ip_i >> (5'd8 * (5'd3 - {3'd0, tpa_k}));

  // Checks: fixed ethertype/htype/ptype/hlen/plen/request opcode, target IP
  always_comb begin
    ok = 1'b1;
    case (pos_q)
      POS_W'(12): ok = (frame_byte_i == 8'h08);
      POS_W'(13): ok = (frame_byte_i == 8'h06);
      POS_W'(14): ok = (frame_byte_i == 8'h00);
      POS_W'(15): ok = (frame_byte_i == 8'h01);
      POS_W'(16): ok = (frame_byte_i == 8'h08);
      POS_W'(17): ok = (frame_byte_i == 8'h00);
      POS_W'(18): ok = (frame_byte_i == 8'h06);
      POS_W'(19): ok = (frame_byte_i == 8'h04);
      POS_W'(20): ok = (frame_byte_i == 8'h00);
      POS_W'(21): ok = (frame_byte_i == 8'h01);
      default: begin
        if (pos_q >= TPA_POS && pos_q < END_POS) begin
          ok = (frame_byte_i == ip_shift[7:0]);
        end
      end
    endcase
  end

  always_comb begin
    pos_d      = pos_q;
    rej_d      = rej_q;
    hw_d       = hw_q;
    ip_d       = ip_q;
    job_push_o = 1'b0;
    if (accept_i) begin
      if (pos_q < END_POS) begin
        if (!ok) begin
          rej_d = 1'b1;
        end
        if (pos_q >= SHA_POS && pos_q < SPA_POS) begin
          hw_d = {hw_q[39:0], frame_byte_i};
        end else if (pos_q >= SPA_POS && pos_q < SPA_END) begin
          ip_d = {ip_q[23:0], frame_byte_i};
        end
        pos_d = pos_q + POS_W'(1);
      end
      if (frame_end_i) begin
        job_push_o = (pos_d == END_POS) && !rej_d;
        pos_d      = '0;
        rej_d      = 1'b0;
      end
    end
  end

  assign job_o.hw_addr    = hw_d;
  assign job_o.proto_addr = ip_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rej_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      rej_q <= rej_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hw_q <= hw_d;
    ip_q <= ip_d;
  end

endmodule

`default_nettype wire

// ----- src/arr_jobq.sv -----
// Short queue of pending reply jobs between the parser and the reply emitter.
// Depends on arr_pkg for the job type.
`default_nettype none

module arr_jobq #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  arr_pkg::job_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output arr_pkg::job_t data_o,
  output logic          empty_o
);
  import arr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/arr_back.sv -----
// Reply emitter: walks the reply frame of the oldest pending job, one word per pop.
// Depends on arr_pkg; reads the head of arr_jobq.
`default_nettype none

module arr_back #(
  parameter int unsigned REPLY_BYTES = 60
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  arr_pkg::job_t    job_i,
  input  wire logic        job_empty_i,
  input  wire logic        pop_i,
  input  wire logic [47:0] station_mac_i,
  input  wire logic [31:0] station_ip_i,
  output logic [7:0]       reply_byte_o,
  output logic             reply_last_o,
  output logic             job_done_o
);
  import arr_pkg::*;

  localparam int unsigned IDX_W = $clog2(REPLY_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_BYTES - 1);

  logic [IDX_W-1:0] idx_q;
  logic [7:0]       i;

  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [7:0] k);
    logic [47:0] s;
    s = mac >> (8'd8 * (8'd5 - k));
    return s[7:0];
  endfunction

  function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [7:0] k);
    logic [31:0] s;
    s = ip >> (8'd8 * (8'd3 - k));
    return s[7:0];
  endfunction

  // ARP reply constants: ethertype, htype, ptype, hlen, plen, reply opcode
  function automatic logic [7:0] fixed_byte(logic [7:0] k);
    logic [7:0] r;
    case (k)
      8'd0:    r = 8'h08;
      8'd1:    r = 8'h06;
      8'd2:    r = 8'h00;
      8'd3:    r = 8'h01;
      8'd4:    r = 8'h08;
      8'd5:    r = 8'h00;
      8'd6:    r = 8'h06;
      8'd7:    r = 8'h04;
      8'd8:    r = 8'h00;
      8'd9:    r = 8'h02;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign i = 8'(idx_q);

  always_comb begin
    if (i < 8'd6) begin
      reply_byte_o = mac_byte(job_i.hw_addr, i);
    end else if (i < 8'd12) begin
      reply_byte_o = mac_byte(station_mac_i, i - 8'd6);
    end else if (i < 8'd22) begin
      reply_byte_o = fixed_byte(i - 8'd12);
    end else if (i < 8'd28) begin
      reply_byte_o = mac_byte(station_mac_i, i - 8'd22);
    end else if (i < 8'd32) begin
      reply_byte_o = ip_byte(station_ip_i, i - 8'd28);
    end else if (i < 8'd38) begin
      reply_byte_o = mac_byte(job_i.hw_addr, i - 8'd32);
    end else if (i < 8'd42) begin
      reply_byte_o = ip_byte(job_i.proto_addr, i - 8'd38);
    end else begin
      reply_byte_o = PAD_BYTE;
    end
  end

  assign reply_last_o = (idx_q == LAST_IDX);
  assign job_done_o   = pop_i && !job_empty_i && reply_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (pop_i && !job_empty_i) begin
      idx_q <= reply_last_o ? '0 : idx_q + IDX_W'(1);
    end
  end

endmodule

`default_nettype wire
